FILE: rtl/msc_pkg.sv
// Shared constants, codes and types of the member set with compaction.
package msc_pkg;

  localparam int MAX_MEMBERS = 64;
  localparam int ID_W = 64;
  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] CAPACITY_RESET = 7'd64;
  localparam logic [CFG_W-1:0] OVERLOAD_RESET = 7'd48;

  localparam logic REG_CAPACITY_LIMIT = 1'b0;
  localparam logic REG_OVERLOAD_COUNT = 1'b1;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TEST = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic cmp_en;
    logic add_en;
    logic shift_en;
  } msc_ctrl_t;

endpackage

FILE: rtl/msc_cell.sv
// One entry of the member list: compare, append and shift-down logic.
module msc_cell #(
  parameter int IDX = 0,
  parameter int CNT_W = 7
) (
  input  logic                     clk,
  input  msc_pkg::msc_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]         count,
  input  logic [CNT_W-1:0]         pos,
  input  logic [msc_pkg::ID_W-1:0] cmd_id,
  input  logic [msc_pkg::ID_W-1:0] upper_entry,
  output logic [msc_pkg::ID_W-1:0] entry,
  output logic                     match
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic in_use;

  assign in_use = MY_IDX < count;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match <= in_use && (entry == cmd_id);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en && (MY_IDX >= pos)) begin
      entry <= upper_entry;
    end else if (ctrl.add_en && (MY_IDX == count)) begin
      entry <= cmd_id;
    end
  end

endmodule

FILE: rtl/msc_pos_enc.sv
// Encodes the one-hot match vector of the cells into the index of the match.
module msc_pos_enc #(
  parameter int MAX = msc_pkg::MAX_MEMBERS,
  parameter int CNT_W = 7
) (
  input  logic [MAX-1:0]   match,
  output logic [CNT_W-1:0] pos,
  output logic             hit
);

  always_comb begin
    pos = '0;
    for (int j = 0; j < MAX; j++) begin
      pos = pos | (match[j] ? CNT_W'(j) : '0);
    end
  end

  assign hit = |match;

endmodule

FILE: rtl/member_set_with_compaction.sv
// Top level of the member set with compaction: control, cell row and result register.
// An item has a compare phase, where the cells compare, then an update phase, where
// the list updates unless the output stalls; a new item is taken when the last one updates.
// The result is registered as the update completes and holds while the output stalls.
// Synchronous reset empties the set and restores the registers; entries need no clearing.
module member_set_with_compaction #(
  parameter int MAX = msc_pkg::MAX_MEMBERS,
  localparam int CNT_W = $clog2(MAX + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [msc_pkg::CFG_W-1:0] wr_data,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic [1:0]                mode,
  input  logic [msc_pkg::ID_W-1:0]  member_id,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [1:0]                status,
  output logic                      present,
  output logic [CNT_W-1:0]          member_count,
  output logic                      overloaded
);

  localparam int CMP_W = (CNT_W > msc_pkg::CFG_W) ? CNT_W : msc_pkg::CFG_W;
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP = 2'd1;
  localparam logic [1:0] PH_UPD = 2'd2;

  logic [1:0]                     phase;
  logic [1:0]                     cmd_mode;
  logic [msc_pkg::ID_W-1:0]       cmd_id;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               count_next;
  logic [msc_pkg::CFG_W-1:0]      capacity_limit;
  logic [msc_pkg::CFG_W-1:0]      overload_count;
  logic [msc_pkg::ID_W-1:0]       entries [MAX];
  logic [MAX-1:0]                 match;
  logic [CNT_W-1:0]               pos;
  logic                           hit;
  logic                           full;
  logic                           finish;
  logic                           accept;
  logic [1:0]                     status_next;
  msc_pkg::msc_ctrl_t             ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= msc_pkg::CAPACITY_RESET;
      overload_count <= msc_pkg::OVERLOAD_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        msc_pkg::REG_CAPACITY_LIMIT: capacity_limit <= wr_data;
        msc_pkg::REG_OVERLOAD_COUNT: overload_count <= wr_data;
      endcase
    end
  end

  assign finish = (phase == PH_UPD) && (!rsp_valid || !rsp_stall);
  assign cmd_stall = !((phase == PH_IDLE) || finish);
  assign accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= PH_CMP;
    end else if (phase == PH_CMP) begin
      phase <= PH_UPD;
    end else if (finish) begin
      phase <= PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode <= mode;
      cmd_id <= member_id;
    end
  end

  msc_pos_enc #(
    .MAX   (MAX),
    .CNT_W (CNT_W)
  ) u_pos_enc (
    .match (match),
    .pos   (pos),
    .hit   (hit)
  );

  assign full = (CMP_W'(count) >= CMP_W'(capacity_limit)) || (count >= MAX_COUNT);

  always_comb begin
    ctrl.cmp_en = (phase == PH_CMP);
    ctrl.add_en = 1'b0;
    ctrl.shift_en = 1'b0;
    status_next = msc_pkg::ST_OK;
    count_next = count;
    unique case (cmd_mode)
      msc_pkg::MODE_ADD: begin
        if (!hit) begin
          if (full) begin
            status_next = msc_pkg::ST_FULL;
          end else begin
            ctrl.add_en = finish;
            count_next = count + CNT_W'(1);
          end
        end
      end
      msc_pkg::MODE_REMOVE: begin
        if (hit) begin
          ctrl.shift_en = finish;
          count_next = count - CNT_W'(1);
        end else begin
          status_next = msc_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar j = 0; j < MAX; j++) begin : g_cell
    logic [msc_pkg::ID_W-1:0] upper;
    if (j == MAX - 1) begin : g_last
      assign upper = entries[j];
    end else begin : g_mid
      assign upper = entries[j+1];
    end
    msc_cell #(
      .IDX   (j),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .pos         (pos),
      .cmd_id      (cmd_id),
      .upper_entry (upper),
      .entry       (entries[j]),
      .match       (match[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (finish) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status <= status_next;
      present <= hit;
      member_count <= count_next;
      overloaded <= (capacity_limit != '0)
                    && (CMP_W'(count_next) > CMP_W'(overload_count));
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT)
    else $error("member count beyond the list size");

  a_cmp_then_upd: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CMP |=> phase == PH_UPD)
    else $error("compare cycle not followed by update cycle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> phase == PH_CMP)
    else $error("accepted transfer did not start a compare");

  a_full_not_present: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == msc_pkg::ST_FULL) |-> !present)
    else $error("full reported for a present member");
`endif

endmodule
